// File: sv/bfa_pkg.sv
// Package for the bitmap first-fit allocator: constants, status and register codes.
// No dependencies.
`timescale 1ns / 1ps
package bfa_pkg;
    localparam int MAX_BLOCKS      = 256;
    localparam int SIZE_WORD_BYTES = 4;
    localparam int BLK_W           = $clog2(MAX_BLOCKS);
    localparam int WORD_W          = 8;
    localparam int WORDS           = MAX_BLOCKS / WORD_W;
    localparam int WADDR_W         = $clog2(WORDS);

    localparam logic [1:0] ST_ALLOC  = 2'd0;
    localparam logic [1:0] ST_REFUSE = 2'd1;
    localparam logic [1:0] ST_FREED  = 2'd2;
    localparam logic [1:0] ST_IGNORE = 2'd3;

    localparam logic [3:2] REG_AREA  = 2'd0;
    localparam logic [3:2] REG_BSIZE = 2'd1;
    localparam logic [3:2] REG_BCNT  = 2'd2;

    typedef logic [BLK_W:0] cnt_t;
endpackage

// File: sv/bitmap_first_fit_allocator.sv
// Top level of the bitmap first-fit allocator: handshakes, registers, sequencer.
// Depends on bfa_pkg.
// An allocate runs the size division, multiply and budget check, then probes bitmap
// bits one at a time (at most block_count probes), marks each block of the run and
// enters the output state; a free runs the offset division and length lookup, then
// clears each block of the run and enters the output state. The serial divider and
// the single-bit bitmap memory port set the pace; one request is in work at a time,
// and the next is taken only after the result register has been emptied. After
// reset a clearing pass over all MAX_BLOCKS entries zeroes both memories; requests
// are held off until it ends.
`timescale 1ns / 1ps
module bitmap_first_fit_allocator import bfa_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // alloc_bytes[15:0], data_offset[31:16]
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // result_offset[15:0], start_block[23:16], used[39:24]
    output logic [1:0]  m_tuser,   // status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_DIV = 4'd2, S_ACHK = 4'd3,
                           S_SCAN = 4'd4, S_SRD = 4'd5, S_MARK = 4'd6, S_FCHK = 4'd7,
                           S_FRD = 4'd8, S_FLEN = 4'd9, S_FCLR = 4'd10, S_OUT = 4'd11,
                           S_MUL = 4'd12;

    logic [15:0] area_reg, bsize_reg;
    logic [8:0]  bcnt_reg;
    logic [15:0] used_reg;
    logic [3:0]  st_reg;
    logic        type_reg;
    logic [16:0] num_reg;      // dividend / quotient
    logic [16:0] rem_reg;
    logic [4:0]  dcnt_reg;
    logic [8:0]  blocks_reg;   // run length
    cnt_t        s_reg;        // candidate start
    cnt_t        k_reg;        // offset into run
    logic [15:0] prod_reg;
    logic        mv_reg;
    logic [1:0]  ost_reg;
    logic [15:0] ooff_reg, oused_reg;
    logic [7:0]  oblk_reg;

    // memories
    logic        occ_mem [MAX_BLOCKS];
    logic [8:0]  len_mem [MAX_BLOCKS];
    logic        occ_q;
    logic [8:0]  len_q;
    logic [BLK_W-1:0] occ_ra, occ_wa, len_a;
    logic        occ_we, occ_wd, len_we;
    logic [8:0]  len_wd;

    always_ff @(posedge aclk) begin
        if (occ_we) occ_mem[occ_wa] <= occ_wd;
        occ_q <= occ_mem[occ_ra];
        if (len_we) len_mem[len_a] <= len_wd;
        len_q <= len_mem[len_a];
    end

    wire [8:0] count = (bcnt_reg[8:3] > 6'(MAX_BLOCKS / 8)) ? 9'(MAX_BLOCKS)
                                                            : {bcnt_reg[8:3], 3'b000};
    cnt_t idx;
    assign idx    = s_reg + k_reg;
    assign occ_ra = idx[BLK_W-1:0];

    wire wr_cfg = psel && penable && pwrite;
    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[3:2])
            REG_AREA:  prdata = {16'd0, area_reg};
            REG_BSIZE: prdata = {16'd0, bsize_reg};
            REG_BCNT:  prdata = {23'd0, bcnt_reg};
            default:   prdata = 32'd0;
        endcase
    end

    assign s_tready = (st_reg == S_IDLE) && !mv_reg;
    assign m_tvalid = mv_reg;
    assign m_tdata  = {oused_reg, oblk_reg, ooff_reg};
    assign m_tuser  = ost_reg;

    // restoring divider step
    wire [17:0] trial = {rem_reg, num_reg[16]} - {2'b0, bsize_reg};
    // budget terms, signed 19-bit
    wire signed [18:0] avail1 = $signed({3'b0, area_reg}) - $signed({3'b0, used_reg})
                                - $signed({13'b0, count[8:3]});
    wire signed [18:0] avail2 = $signed({3'b0, area_reg}) - $signed({3'b0, used_reg});
    wire [16:0] size = {1'b0, s_tdata[15:0]} + 17'(SIZE_WORD_BYTES);
    logic [32:0] rbytes;
    assign rbytes = {num_reg, 16'd0} == 33'd0 ? 33'd0 : 33'(num_reg) * 33'(bsize_reg);
    logic [32:0] rbytes_reg;

    always_comb begin
        occ_we = 1'b0; occ_wa = occ_ra; occ_wd = 1'b0;
        len_we = 1'b0; len_wd = 9'd0;
        len_a  = s_reg[BLK_W-1:0];
        unique case (st_reg)
            S_CLR:  begin occ_we = 1'b1; occ_wa = k_reg[BLK_W-1:0];
                          len_we = 1'b1; len_a = k_reg[BLK_W-1:0]; end
            S_MARK: begin occ_we = 1'b1; occ_wd = 1'b1;
                          if (k_reg == '0) begin len_we = 1'b1; len_wd = blocks_reg; end
                    end
            S_FCLR: begin occ_we = 1'b1;
                          if (k_reg == '0) len_we = 1'b1; end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            area_reg <= 16'd65535; bsize_reg <= 16'd16; bcnt_reg <= 9'd256;
            used_reg <= '0; st_reg <= S_CLR; k_reg <= '0; s_reg <= '0; mv_reg <= 1'b0;
        end else begin
            if (wr_cfg) begin
                unique case (paddr[3:2])
                    REG_AREA:  area_reg  <= pwdata[15:0];
                    REG_BSIZE: bsize_reg <= pwdata[15:0];
                    REG_BCNT:  bcnt_reg  <= pwdata[8:0];
                    default: ;
                endcase
            end
            if (mv_reg && m_tready) mv_reg <= 1'b0;
            unique case (st_reg)
                S_CLR: begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == cnt_t'(MAX_BLOCKS - 1)) begin k_reg <= '0; st_reg <= S_IDLE; end
                end
                S_IDLE: if (s_tvalid && s_tready) begin
                    type_reg <= s_tuser;
                    rem_reg <= '0; dcnt_reg <= '0; s_reg <= '0; k_reg <= '0;
                    ooff_reg <= '0; oblk_reg <= '0;
                    if (!s_tuser) begin
                        num_reg <= size + 17'(bsize_reg) - 17'd1;
                        if (s_tdata[15:0] == 16'd0 || bsize_reg == 16'd0 ||
                            $signed({2'b0, size}) > avail1) begin
                            ost_reg <= ST_REFUSE; st_reg <= S_OUT;
                        end else st_reg <= S_DIV;
                    end else begin
                        num_reg <= {1'b0, s_tdata[31:16]} - 17'(SIZE_WORD_BYTES);
                        if (bsize_reg == 16'd0 || s_tdata[31:16] < 16'(SIZE_WORD_BYTES)) begin
                            ost_reg <= ST_IGNORE; st_reg <= S_OUT;
                        end else st_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    // one quotient bit per cycle
                    if (!trial[17]) begin
                        rem_reg <= trial[16:0];
                        num_reg <= {num_reg[15:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[15:0], num_reg[16]};
                        num_reg <= {num_reg[15:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == 5'd16) st_reg <= S_MUL;
                end
                S_MUL: begin
                    rbytes_reg <= rbytes;
                    st_reg <= type_reg ? S_FCHK : S_ACHK;
                end
                S_ACHK: begin
                    if ($signed({1'b0, rbytes_reg}) > $signed({{15{avail2[18]}}, avail2}) ||
                        num_reg > {8'd0, count}) begin
                        ost_reg <= ST_REFUSE; st_reg <= S_OUT;
                    end else begin
                        blocks_reg <= num_reg[8:0]; st_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // probe bit s+k; done when whole run checked, refused when the run would pass count
                    if ({1'b0, s_reg} + {1'b0, blocks_reg} > {1'b0, count}) begin
                        ost_reg <= ST_REFUSE; st_reg <= S_OUT;
                    end else if (k_reg == cnt_t'(blocks_reg)) begin
                        k_reg <= '0; st_reg <= S_MARK;
                    end else st_reg <= S_SRD;
                end
                S_SRD: begin
                    if (occ_q) begin s_reg <= idx + 1'b1; k_reg <= '0; end
                    else k_reg <= k_reg + 1'b1;
                    st_reg <= S_SCAN;
                end
                S_MARK: begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == cnt_t'(blocks_reg - 9'd1)) begin
                        used_reg <= used_reg + rbytes_reg[15:0];
                        ost_reg <= ST_ALLOC;
                        prod_reg <= 16'(s_reg) * bsize_reg;
                        oblk_reg <= s_reg[7:0];
                        st_reg <= S_OUT;
                    end
                end
                S_FCHK: begin
                    if (num_reg >= {8'd0, count}) begin
                        ost_reg <= ST_IGNORE; st_reg <= S_OUT;
                    end else begin
                        s_reg <= num_reg[BLK_W:0]; st_reg <= S_FRD;
                    end
                end
                S_FRD: st_reg <= S_FLEN;
                S_FLEN: begin
                    blocks_reg <= len_q; num_reg <= 17'(len_q);
                    if (len_q == 9'd0 || {1'b0, s_reg} + {1'b0, len_q} > {1'b0, count}) begin
                        ost_reg <= ST_IGNORE; st_reg <= S_OUT;
                    end else st_reg <= S_FCLR;
                end
                S_FCLR: begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == cnt_t'(blocks_reg - 9'd1)) begin
                        ost_reg <= ST_FREED; oblk_reg <= s_reg[7:0];
                        st_reg <= S_OUT; rbytes_reg <= rbytes;
                    end
                end
                S_OUT: begin
                    if (ost_reg == ST_FREED)
                        used_reg <= (rbytes_reg > 33'(used_reg)) ? 16'd0
                                    : used_reg - rbytes_reg[15:0];
                    if (ost_reg == ST_ALLOC) ooff_reg <= prod_reg + 16'(SIZE_WORD_BYTES);
                    mv_reg <= 1'b1; st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (st_reg == S_OUT) begin
            if (ost_reg == ST_FREED)
                oused_reg <= (rbytes_reg > 33'(used_reg)) ? 16'd0
                             : used_reg - rbytes_reg[15:0];
            else oused_reg <= used_reg;
        end
    end
endmodule
